// File: hw/rtl/lspp_pkg.sv
// ----------------------------------------------------------------------------
// lspp_pkg
// Shared constants, reading type and decode function for the scan packet parser.
// ----------------------------------------------------------------------------
package lspp_pkg;

   localparam int PACKET_BYTES = 22;
   localparam int CHAIN_CELLS  = PACKET_BYTES - 1;   // start byte is not kept
   localparam int READINGS     = 4;
   localparam int POS_W        = 5;
   localparam int BYTE_W       = 8;
   localparam int ANGLE_W      = 9;
   localparam int DIST_W       = 14;
   localparam int PKT_W        = 7;

   localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(PACKET_BYTES - 1);
   localparam logic [POS_W-1:0]  FIRST_POS  = '0;
   localparam logic [BYTE_W-1:0] START_MARK = 8'hFA;
   localparam logic [BYTE_W-1:0] INDEX_BASE = 8'hA0;
   localparam logic [BYTE_W-1:0] INDEX_TOP  = 8'hF9;
   localparam int                INVALID_BIT = 7;

   typedef struct packed {
      logic               valid;
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  distance;
      logic               invalid;
      logic               last;
   } reading_type;

   // Build one reading from its packet number, slot and two distance bytes.
   function automatic reading_type make_reading(input logic [PKT_W-1:0]  pkt,
                                                input logic [1:0]        slot,
                                                input logic [BYTE_W-1:0] lo,
                                                input logic [BYTE_W-1:0] hi);
      reading_type r;
      r.valid    = 1'b1;
      r.angle    = {pkt, slot};
      r.invalid  = hi[INVALID_BIT];
      r.distance = hi[INVALID_BIT] ? '0 : {hi[DIST_W-BYTE_W-1:0], lo};
      r.last     = (slot == 2'(READINGS - 1));
      return r;
   endfunction

endpackage

// File: hw/rtl/lspp_if.sv
// ----------------------------------------------------------------------------
// lspp request / response channels
// Valid-ready channels for received bytes and decoded readings.
// ----------------------------------------------------------------------------
interface lspp_req_if;
   logic                        valid;
   logic                        ready;
   logic [lspp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lspp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lspp_pkg::ANGLE_W-1:0] angle;
   logic [lspp_pkg::DIST_W-1:0]  distance;
   logic                         invalid;
   logic                         last;

   modport source (output valid, output angle, output distance, output invalid,
                   output last, input ready);
   modport sink   (input valid, input angle, input distance, input invalid,
                   input last, output ready);
endinterface

// File: hw/rtl/lidar_scan_packet_parser_core.sv
// ----------------------------------------------------------------------------
// lidar_scan_packet_parser_core
// Scan packet parser: byte capture chain feeding a four-slot reading chain.
// ----------------------------------------------------------------------------
// The last packet byte sets load_ff; the reading chain then loads and the first
// reading shows on rsp. Throughput: one byte per cycle while req_ready is high;
//   readings leave one per cycle from the reading chain head while rsp ready is high.
// req_ready drops only on a packet's last byte while readings are still held.
// Reset (synchronous): back to waiting for a start byte; reading chain empty.
module lidar_scan_packet_parser_core (
   input  logic       clock,
   input  logic       reset,
   lspp_req_if.sink   req_bus,
   lspp_rsp_if.source rsp_bus
);
   import lspp_pkg::*;

   // Capture control
   logic             capturing_ff, capturing_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic             load_ff, load_in;    // packet done, decode next cycle

   logic req_fire;
   logic rsp_fire;
   logic is_start;
   logic cap_now;
   logic shift_en;
   logic rd_busy;

   // Byte chain: cell 0 holds the newest byte. After a full packet, cell j
   // holds packet position CHAIN_CELLS - j (position 0, the start byte, is
   // never stored).
   logic [BYTE_W-1:0] chain_byte [CHAIN_CELLS];

   // Reading chain: cell 0 is the output register.
   reading_type rd_cell [READINGS];
   reading_type rd_load_data [READINGS];

   logic [BYTE_W-1:0] index_byte;
   logic              index_ok;
   logic [PKT_W-1:0]  pkt_num;
   logic [BYTE_W-1:0] index_off;
   logic              rd_load;

   assign is_start = (req_bus.rx_byte == START_MARK);
   assign cap_now  = capturing_ff || is_start;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   // Readings pending or about to be loaded: hold the byte that would
   // finish the next packet until the reading chain drains.
   assign rd_busy       = rd_cell[0].valid || load_ff;
   assign req_bus.ready = !(capturing_ff && (position_ff == LAST_POS) && rd_busy);

   // A start byte mid-packet is just data; only idle + start opens a packet.
   assign shift_en = req_fire && cap_now && (position_ff != FIRST_POS);

   always_comb begin
      capturing_in = capturing_ff;
      position_in  = position_ff;
      load_in      = 1'b0;
      if (req_fire && cap_now) begin
         if (position_ff == LAST_POS) begin
            position_in  = FIRST_POS;
            capturing_in = 1'b0;
            load_in      = 1'b1;
         end else begin
            position_in  = position_ff + POS_W'(1);
            capturing_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         position_ff  <= FIRST_POS;
         load_ff      <= 1'b0;
      end else begin
         capturing_ff <= capturing_in;
         position_ff  <= position_in;
         load_ff      <= load_in;
      end
   end

   // Byte capture chain
   genvar j;
   generate
      for (j = 0; j < CHAIN_CELLS; j++) begin : g_byte
         if (j == 0) begin : g_head
            lspp_byte_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .byte_in  (req_bus.rx_byte),
               .byte_out (chain_byte[j])
            );
         end else begin : g_body
            lspp_byte_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .byte_in  (chain_byte[j-1]),
               .byte_out (chain_byte[j])
            );
         end
      end
   endgenerate

   // Index byte sits in the oldest cell (packet position one).
   assign index_byte = chain_byte[CHAIN_CELLS-1];
   assign index_ok   = (index_byte >= INDEX_BASE) && (index_byte <= INDEX_TOP);
   assign index_off  = index_byte - INDEX_BASE;
   assign pkt_num    = index_off[PKT_W-1:0];
   // Bad index: packet dropped, nothing loaded.
   assign rd_load    = load_ff && index_ok;

   // Reading chain; reading k uses positions 4+4k (low) and 5+4k (high).
   genvar k;
   generate
      for (k = 0; k < READINGS; k++) begin : g_read
         localparam int LO_CELL = CHAIN_CELLS - 4 - 4 * k;
         localparam int HI_CELL = CHAIN_CELLS - 5 - 4 * k;

         assign rd_load_data[k] = make_reading(pkt_num, 2'(k),
                                               chain_byte[LO_CELL],
                                               chain_byte[HI_CELL]);

         if (k == READINGS - 1) begin : g_tail
            lspp_read_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .load      (rd_load),
               .shift     (rsp_fire),
               .load_data (rd_load_data[k]),
               .next_data ('0),
               .cell_data (rd_cell[k])
            );
         end else begin : g_body
            lspp_read_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .load      (rd_load),
               .shift     (rsp_fire),
               .load_data (rd_load_data[k]),
               .next_data (rd_cell[k+1]),
               .cell_data (rd_cell[k])
            );
         end
      end
   endgenerate

   assign rsp_bus.valid    = rd_cell[0].valid;
   assign rsp_bus.angle    = rd_cell[0].angle;
   assign rsp_bus.distance = rd_cell[0].distance;
   assign rsp_bus.invalid  = rd_cell[0].invalid;
   assign rsp_bus.last     = rd_cell[0].last;

endmodule

// File: hw/rtl/lspp_byte_cell.sv
// ----------------------------------------------------------------------------
// lspp_byte_cell
// One byte stage of the packet capture chain.
// ----------------------------------------------------------------------------
module lspp_byte_cell (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [lspp_pkg::BYTE_W-1:0] byte_in,
   output logic [lspp_pkg::BYTE_W-1:0] byte_out
);
   import lspp_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in_nxt;

   assign byte_in_nxt = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_nxt;
   end

   assign byte_out = byte_ff;

endmodule

// File: hw/rtl/lspp_read_cell.sv
// ----------------------------------------------------------------------------
// lspp_read_cell
// One slot of the reading output chain: parallel load, shift toward the head.
// ----------------------------------------------------------------------------
module lspp_read_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  shift,
   input  lspp_pkg::reading_type load_data,
   input  lspp_pkg::reading_type next_data,
   output lspp_pkg::reading_type cell_data
);
   import lspp_pkg::*;

   reading_type cell_ff;
   reading_type cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (load) begin
         cell_in = load_data;
      end else if (shift) begin
         cell_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.angle    <= cell_in.angle;
      cell_ff.distance <= cell_in.distance;
      cell_ff.invalid  <= cell_in.invalid;
      cell_ff.last     <= cell_in.last;
   end

   assign cell_data = cell_ff;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the lidar scan packet parser. Received bytes are fed through
// the request channel and every decoded reading on the response channel is
// checked against an in-bench packet decoder. Directed packets come first,
// then a long run of random packets mixed with bad-index packets and stray
// bytes, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import lspp_pkg::*;

   // One decoded reading as it appears on the response channel.
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  distance;
      logic               invalid;
      logic               last;
   } rsp_reading_type;

   // A directed packet. The body holds packet positions 2..21; the rows here
   // keep the speed and checksum positions at one filler byte and list the
   // four distance pairs separately. Where typed is set, the expected readings
   // are written out in the row instead of being taken from the decoder.
   typedef struct packed {
      logic [BYTE_W-1:0]           noise;        // stray byte before the start
      logic [BYTE_W-1:0]           index;
      logic [BYTE_W-1:0]           filler;
      logic [3:0][BYTE_W-1:0]      lo;           // reading 0 in bits 7:0
      logic [3:0][BYTE_W-1:0]      hi;
      logic                        typed;
      logic                        has_readings;
      logic [ANGLE_W-1:0]          first_angle;
      logic [3:0][DIST_W-1:0]      dist_want;
      logic [3:0]                  inval;
   } packet_row_type;

   localparam int NUM_DIRECTED = 8;
   localparam int RANDOM_BYTES = 176;
   localparam int IDLE_PCT     = 38;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;    // idle margin after the owed readings drain
   localparam int MAX_PRINTS   = 40;

   // Directed packets: lowest and highest packet numbers, full-scale and
   // masked distances, invalid flags, start marks inside a packet, bad indexes
   // on both sides of the valid range and stray bytes before most starts.
   localparam packet_row_type DIRECTED [NUM_DIRECTED] = '{
      // packet 0: zero, full scale, invalid, bit 6 of high byte dropped
      '{8'h00, 8'hA0, 8'h00, 32'hAA55FF00, 32'h7F803F00, 1'b1, 1'b1, 9'd0,
        {14'h3FAA, 14'h0000, 14'h3FFF, 14'h0000}, 4'b0100},
      // last packet number, start marks stored as data in the filler and two low bytes
      '{8'hFF, 8'hF9, 8'hFA, 32'hFF00FAFA, 32'h152A40FF, 1'b1, 1'b1, 9'd356,
        {14'h15FF, 14'h2A00, 14'h00FA, 14'h0000}, 4'b0001},
      // bad index just below and just above the valid range
      '{8'hF9, 8'h9F, 8'h11, 32'h12345678, 32'h9ABCDEF0, 1'b1, 1'b0, 9'd0,
        '0, 4'b0000},
      '{8'hFB, 8'hFA, 8'h22, 32'h87654321, 32'h0FEDCBA9, 1'b1, 1'b0, 9'd0,
        '0, 4'b0000},
      // bad index at the byte extremes
      '{8'h01, 8'h00, 8'hFF, 32'hFFFFFFFF, 32'h3F3F3F3F, 1'b1, 1'b0, 9'd0,
        '0, 4'b0000},
      '{8'h80, 8'hFF, 8'h00, 32'h00000000, 32'h00000000, 1'b1, 1'b0, 9'd0,
        '0, 4'b0000},
      // ordinary packets, left to the decoder
      '{8'h7F, 8'hC5, 8'h5A, 32'h01020408, 32'hC0817F3E, 1'b0, 1'b0, 9'd0,
        '0, 4'b0000},
      '{8'hFA, 8'hA1, 8'hA5, 32'h10204080, 32'h3E81FF01, 1'b0, 1'b0, 9'd0,
        '0, 4'b0000}
   };

   logic clock;
   logic reset;

   lspp_req_if req_if ();
   lspp_rsp_if rsp_if ();

   lidar_scan_packet_parser_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Decoder state: mirrors the block's capture state.
   logic              capturing;
   logic [POS_W-1:0]  byte_pos;
   logic [BYTE_W-1:0] packet_bytes [PACKET_BYTES];

   rsp_reading_type readings_due [$];   // readings still owed by the block
   int       mismatches;
   int       cycle_count;
   logic     calm;               // set: neither side idles

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. Falls through only when the run hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic take_break();
      return !calm && ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // Decoder: takes one accepted byte, updates the capture state and returns
   // the number of readings that byte completes (0 or 4).
   function automatic int capture_byte(input logic [BYTE_W-1:0] b,
                                       output rsp_reading_type [3:0] rd);
      logic [BYTE_W-1:0] idx;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [PKT_W-1:0]  pkt_num;
      rd = '0;
      if (b == START_MARK)
         capturing = 1'b1;
      if (!capturing)
         return 0;                // stray byte while waiting for a start
      packet_bytes[byte_pos] = b;
      if (byte_pos != LAST_POS) begin
         byte_pos++;
         return 0;
      end
      byte_pos  = FIRST_POS;
      capturing = 1'b0;
      idx       = packet_bytes[1];
      if (idx < INDEX_BASE || idx > INDEX_TOP)
         return 0;                // bad index, packet dropped
      pkt_num = PKT_W'(idx - INDEX_BASE);
      for (int k = 0; k < READINGS; k++) begin
         lo                = packet_bytes[4 + 4 * k];
         hi                = packet_bytes[5 + 4 * k];
         rd[k].angle       = ANGLE_W'(pkt_num * 4 + k);
         rd[k].invalid     = hi[INVALID_BIT];
         rd[k].distance    = hi[INVALID_BIT] ? '0 : {hi[5:0], lo};
         rd[k].last        = (k == READINGS - 1);
      end
      return READINGS;
   endfunction

   // One byte transfer. Random idle cycles go in front; the handshake is
   // sampled at the falling edge, where every signal has settled, and takes
   // effect at the next rising edge.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic trust_decoder);
      logic     taken;
      int       n;
      rsp_reading_type [3:0] rd;
      while (take_break()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end while (!taken);
      n = capture_byte(b, rd);
      if (trust_decoder)
         for (int k = 0; k < n; k++)
            readings_due.push_back(rd[k]);
   endtask

   // Start mark, index, then packet positions 2..21.
   task automatic send_packet(input logic [BYTE_W-1:0] idx,
                              input logic [19:0][BYTE_W-1:0] body,
                              input logic trust_decoder);
      send_byte(START_MARK, trust_decoder);
      send_byte(idx, trust_decoder);
      for (int j = 0; j < 20; j++)
         send_byte(body[j], trust_decoder);
   endtask

   task automatic wait_for_drain();
      while (readings_due.size() != 0)
         @(posedge clock);
   endtask

   // Response side: random back-pressure, field-by-field compare against the
   // oldest reading owed.
   initial begin : rsp_side
      logic     fire;
      rsp_reading_type seen;
      rsp_reading_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         fire = !reset && rsp_if.valid && rsp_if.ready;
         seen = '{rsp_if.angle, rsp_if.distance, rsp_if.invalid, rsp_if.last};
         @(posedge clock);
         if (fire) begin
            if (readings_due.size() == 0) begin
               report_mismatch($sformatf("reading angle %0d with none expected",
                                         seen.angle));
            end else begin
               want = readings_due.pop_front();
               if (seen.angle !== want.angle)
                  report_mismatch($sformatf("angle %0d, expected %0d",
                                            seen.angle, want.angle));
               if (seen.distance !== want.distance)
                  report_mismatch($sformatf("angle %0d: distance %0d, expected %0d",
                                            want.angle, seen.distance, want.distance));
               if (seen.invalid !== want.invalid)
                  report_mismatch($sformatf("angle %0d: invalid %0b, expected %0b",
                                            want.angle, seen.invalid, want.invalid));
               if (seen.last !== want.last)
                  report_mismatch($sformatf("angle %0d: last %0b, expected %0b",
                                            want.angle, seen.last, want.last));
            end
         end
         rsp_if.ready <= !take_break();
      end
   end

   initial begin : stimulus
      packet_row_type            row;
      logic [19:0][BYTE_W-1:0]   body;
      rsp_reading_type           r;
      logic [BYTE_W-1:0]         idx;
      logic [BYTE_W-1:0]         b;
      int                        random_sent;
      int                        pkt_count;
      int                        pick;

      mismatches     = 0;
      calm           = 1'b0;
      capturing      = 1'b0;
      byte_pos       = FIRST_POS;
      foreach (packet_bytes[i])
         packet_bytes[i] = '0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed packets ----
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED[i];
         // a stray byte is ignored while idle; a start mark here would open
         // a packet, so that value means no stray byte
         if (row.noise != START_MARK)
            send_byte(row.noise, 1'b1);
         body = '0;
         body[0]  = row.filler;
         body[1]  = row.filler;
         body[18] = row.filler;
         body[19] = row.filler;
         for (int k = 0; k < READINGS; k++) begin
            body[2 + 4 * k] = row.lo[k];
            body[3 + 4 * k] = row.hi[k];
         end
         send_packet(row.index, body, !row.typed);
         // typed rows: push the readings written in the table, right after the
         // last byte transfer and well before the first reading can show
         if (row.typed && row.has_readings)
            for (int k = 0; k < READINGS; k++) begin
               r.angle    = row.first_angle + ANGLE_W'(k);
               r.distance = row.dist_want[k];
               r.invalid  = row.inval[k];
               r.last     = (k == READINGS - 1);
               readings_due.push_back(r);
            end
      end

      // sender holds off until every reading so far has been taken
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait_for_drain();

      // ---- random part ----
      // Mostly well-formed packets with random content; some bad-index packets
      // and bursts of stray bytes between packets. A calm stretch in the
      // middle runs both channels without any idling.
      random_sent = 0;
      pkt_count   = 0;
      while (random_sent < RANDOM_BYTES) begin
         calm = (pkt_count >= 2 && pkt_count < 6);
         pick = $urandom_range(0, 99);
         if (pick >= 90) begin
            // stray bytes while idle: ignored, not counted
            repeat ($urandom_range(1, 4)) begin
               b = $urandom_range(0, 255);
               if (b == START_MARK)
                  b = START_MARK + 8'd1;
               send_byte(b, 1'b1);
            end
         end else begin
            if (pick < 80)
               idx = $urandom_range(INDEX_BASE, INDEX_TOP);
            else if ($urandom_range(0, 1))
               idx = $urandom_range(0, INDEX_BASE - 1);
            else
               idx = $urandom_range(INDEX_TOP + 1, 255);
            for (int j = 0; j < 20; j++) begin
               body[j] = $urandom_range(0, 255);
               if ($urandom_range(0, 7) == 0)
                  body[j] = START_MARK;
               // high distance bytes: lean on both sides of the invalid bit
               if (j % 4 == 3 && j < 18)
                  case ($urandom_range(0, 3))
                     0: body[j][INVALID_BIT] = 1'b1;
                     1: body[j][INVALID_BIT] = 1'b0;
                     default: ;
                  endcase
            end
            send_packet(idx, body, 1'b1);
            random_sent += PACKET_BYTES;
            pkt_count++;
            // a second full hold-off partway through
            if (pkt_count == 7) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               wait_for_drain();
            end
         end
      end
      calm = 1'b0;
      req_if.valid <= 1'b0;

      // ---- wind-down ----
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (readings_due.size() != 0)
         report_mismatch($sformatf("%0d readings never arrived", readings_due.size()));

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
